// File: rtl/abx_pkg.sv
// Package for the aligned block extractor: shared constants, the queue status
// type and the helper that sizes one queue entry. No dependencies.
package abx_pkg;

    localparam int ABX_MAX_SLAVES   = 8;
    localparam int ABX_POS_BITS     = 16;
    localparam int ABX_NUM_PORTS    = 8;
    localparam int ABX_CNT_W        = 4;
    localparam int ABX_ROW_W        = 4;
    localparam int ABX_QUEUE_DEPTH  = 2;
    localparam logic [ABX_CNT_W-1:0] ABX_CFG_RESET = 4'd1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One block: master from, master to, width, then one start per slave.
    function automatic int abx_block_width(input int max_slaves, input int pos_bits);
        return (3 + max_slaves) * pos_bits;
    endfunction

    // One entry: slave count, two block-present flags, two blocks.
    function automatic int abx_entry_width(input int max_slaves, input int pos_bits);
        return ABX_CNT_W + 2 + 2 * abx_block_width(max_slaves, pos_bits);
    endfunction

endpackage

// File: rtl/abx_queue.sv
// Short register queue between the front and back parts of the block.
// Depends on abx_pkg for the status type.
module abx_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = abx_pkg::ABX_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output abx_pkg::t_q_status   o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

// File: rtl/abx_front.sv
// Front part: holds the slave count and the open block, checks each residue
// and queues the blocks it closes. Depends on abx_pkg.
module abx_front #(
    parameter int MAX_SLAVES = abx_pkg::ABX_MAX_SLAVES,
    parameter int POS_BITS   = abx_pkg::ABX_POS_BITS,
    parameter int ENTRY_W    = abx_pkg::abx_entry_width(MAX_SLAVES, POS_BITS)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [abx_pkg::ABX_CNT_W-1:0]        i_cfg_data,
    output logic                                 o_cfg_ready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [MAX_SLAVES-1:0][POS_BITS:0]    i_slave_pos,
    input  logic                                 i_last_residue,
    input  abx_pkg::t_q_status                   i_q_status,
    output logic                                 o_push,
    output logic [ENTRY_W-1:0]                   o_entry
);

    localparam int CNT_W = abx_pkg::ABX_CNT_W;
    localparam int BLK_W = abx_pkg::abx_block_width(MAX_SLAVES, POS_BITS);

    logic [CNT_W-1:0]                  r_cfg;
    logic                              r_open, n_open;
    logic [POS_BITS-1:0]               r_ms, n_ms;
    logic [POS_BITS-1:0]               r_mi, n_mi;
    logic [MAX_SLAVES-1:0][POS_BITS-1:0] r_ss, n_ss;

    logic [CNT_W-1:0]                  w_ns;
    logic [MAX_SLAVES-1:0]             w_act;
    logic [MAX_SLAVES-1:0]             w_neg;
    logic [MAX_SLAVES-1:0]             w_match;
    logic [MAX_SLAVES-1:0][POS_BITS-1:0] w_posv;
    logic [POS_BITS-1:0]               w_moff;
    logic [POS_BITS-1:0]               w_idx_m1;
    logic                              w_aligned;
    logic                              w_extend;
    logic                              w_keep;
    logic                              w_open_after;
    logic                              w_has_a;
    logic                              w_has_b;
    logic                              w_acc;
    logic [BLK_W-1:0]                  w_blk_a;
    logic [BLK_W-1:0]                  w_blk_b;

    assign o_cfg_ready = 1'b1;
    assign w_ns = (r_cfg > CNT_W'(MAX_SLAVES)) ? CNT_W'(MAX_SLAVES) : r_cfg;

    assign w_moff   = r_mi - r_ms;
    assign w_idx_m1 = r_mi - POS_BITS'(1);

    // Only active slaves take part; a negative position means unaligned.
    always_comb begin
        for (int k = 0; k < MAX_SLAVES; k++) begin
            w_act[k]   = (CNT_W'(k) < w_ns);
            w_neg[k]   = i_slave_pos[k][POS_BITS];
            w_posv[k]  = w_neg[k] ? '0 : i_slave_pos[k][POS_BITS-1:0];
            w_match[k] = ((w_posv[k] - r_ss[k]) == w_moff);
        end
    end

    assign w_aligned    = &(~w_act | ~w_neg);
    assign w_extend     = w_aligned && (&(~w_act | w_match));
    assign w_keep       = r_open && w_extend;
    assign w_open_after = w_keep || w_aligned;
    assign w_has_a      = r_open && !w_extend;
    assign w_has_b      = i_last_residue && w_open_after;

    // Start of the block that is open once this residue is taken.
    always_comb begin
        n_ms = w_keep ? r_ms : r_mi;
        for (int k = 0; k < MAX_SLAVES; k++) begin
            n_ss[k] = (w_keep || !w_act[k]) ? r_ss[k] : w_posv[k];
        end
    end

    assign w_blk_a = {r_ss, w_idx_m1 - r_ms, w_idx_m1, r_ms};
    assign w_blk_b = {n_ss, r_mi - n_ms, r_mi, n_ms};

    assign w_acc      = i_in_valid && !i_q_status.full;
    assign o_in_stall = i_q_status.full;
    assign o_push     = w_acc && (w_has_a || w_has_b);
    assign o_entry    = {w_ns, w_has_a, w_has_b, w_blk_a, w_blk_b};

    always_comb begin
        n_open = r_open;
        n_mi   = r_mi;
        if (w_acc) begin
            n_open = i_last_residue ? 1'b0 : w_open_after;
            n_mi   = i_last_residue ? '0 : r_mi + POS_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= abx_pkg::ABX_CFG_RESET;
            r_open <= 1'b0;
            r_ms   <= '0;
            r_mi   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            r_open <= n_open;
            r_mi   <= n_mi;
            if (w_acc) begin
                r_ms <= n_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ss <= n_ss;
        end
    end

endmodule

// File: rtl/abx_back.sv
// Back part: walks the queued blocks and sends one row per beat through an
// output register. Depends on abx_pkg.
module abx_back #(
    parameter int MAX_SLAVES = abx_pkg::ABX_MAX_SLAVES,
    parameter int POS_BITS   = abx_pkg::ABX_POS_BITS,
    parameter int ENTRY_W    = abx_pkg::abx_entry_width(MAX_SLAVES, POS_BITS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ENTRY_W-1:0]             i_entry,
    input  abx_pkg::t_q_status             i_q_status,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [abx_pkg::ABX_ROW_W-1:0]  o_row,
    output logic [POS_BITS-1:0]            o_range_from,
    output logic [POS_BITS-1:0]            o_range_to,
    output logic                           o_last_row
);

    localparam int CNT_W = abx_pkg::ABX_CNT_W;
    localparam int ROW_W = abx_pkg::ABX_ROW_W;
    localparam int BLK_W = abx_pkg::abx_block_width(MAX_SLAVES, POS_BITS);
    localparam int IDX_W = (MAX_SLAVES > 1) ? $clog2(MAX_SLAVES) : 1;

    logic                 r_valid, n_valid;
    logic [ROW_W-1:0]     r_row, n_row;
    logic                 r_blk, n_blk;
    logic [ROW_W-1:0]     r_out_row, n_out_row;
    logic [POS_BITS-1:0]  r_from, n_from;
    logic [POS_BITS-1:0]  r_to, n_to;
    logic                 r_last, n_last;

    logic [CNT_W-1:0]     w_ns;
    logic                 w_has_a;
    logic                 w_has_b;
    logic                 w_cur_b;
    logic                 w_last_blk;
    logic [BLK_W-1:0]     w_cur;
    logic [POS_BITS-1:0]  w_mfrom;
    logic [POS_BITS-1:0]  w_mto;
    logic [POS_BITS-1:0]  w_width;
    logic [MAX_SLAVES-1:0][POS_BITS-1:0] w_sfrom;
    logic [ROW_W-1:0]     w_row_m1;
    logic [IDX_W-1:0]     w_k;
    logic                 w_row_end;
    logic                 w_adv;
    logic                 w_go;

    assign w_ns    = i_entry[ENTRY_W-1 -: CNT_W];
    assign w_has_a = i_entry[ENTRY_W-CNT_W-1];
    assign w_has_b = i_entry[ENTRY_W-CNT_W-2];

    // The closing block goes out before the block flushed by a last residue.
    assign w_cur_b    = r_blk || !w_has_a;
    assign w_last_blk = w_cur_b || !w_has_b;
    assign w_cur      = w_cur_b ? i_entry[BLK_W-1:0] : i_entry[2*BLK_W-1:BLK_W];

    assign w_mfrom  = w_cur[POS_BITS-1:0];
    assign w_mto    = w_cur[2*POS_BITS-1:POS_BITS];
    assign w_width  = w_cur[3*POS_BITS-1:2*POS_BITS];
    assign w_sfrom  = w_cur[BLK_W-1:3*POS_BITS];
    assign w_row_m1 = r_row - ROW_W'(1);
    assign w_k      = w_row_m1[IDX_W-1:0];

    assign w_row_end = (r_row == ROW_W'(w_ns));
    assign w_adv     = !r_valid || !i_out_stall;
    assign w_go      = w_adv && !i_q_status.empty;
    assign o_pop     = w_go && w_row_end && w_last_blk;

    always_comb begin
        n_valid   = r_valid;
        n_row     = r_row;
        n_blk     = r_blk;
        n_out_row = r_out_row;
        n_from    = r_from;
        n_to      = r_to;
        n_last    = r_last;
        if (w_adv) begin
            n_valid = !i_q_status.empty;
        end
        if (w_go) begin
            n_out_row = r_row;
            n_last    = w_row_end;
            if (r_row == '0) begin
                n_from = w_mfrom;
                n_to   = w_mto;
            end else begin
                n_from = w_sfrom[w_k];
                n_to   = w_sfrom[w_k] + w_width;
            end
            if (w_row_end) begin
                n_row = '0;
                n_blk = !w_last_blk;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= '0;
            r_blk   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_row   <= n_row;
            r_blk   <= n_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row <= n_out_row;
        r_from    <= n_from;
        r_to      <= n_to;
        r_last    <= n_last;
    end

    assign o_out_valid  = r_valid;
    assign o_row        = r_out_row;
    assign o_range_from = r_from;
    assign o_range_to   = r_to;
    assign o_last_row   = r_last;

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty)
        else $error("queue popped while empty");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> (r_row <= ROW_W'(w_ns)))
        else $error("row counter ran past the slave count");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid right after reset");

endmodule

// File: rtl/aligned_block_extractor.sv
// Top level of the aligned block extractor: front checker, block queue and
// row emitter. Depends on abx_pkg, abx_front, abx_queue and abx_back.
//
// One master residue is taken per clock while the block queue has room. Each
// closed block leaves as slave_count+1 output beats, one row per unstalled clock
// from the back part's row counter; a last residue that closes one block and
// opens another queues both in one entry. The two-entry queue between the parts
// sets how far input may run ahead of row output: input stalls only when it is full.
module aligned_block_extractor #(
    parameter int MAX_SLAVES = abx_pkg::ABX_MAX_SLAVES,
    parameter int POS_BITS   = abx_pkg::ABX_POS_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [abx_pkg::ABX_CNT_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [POS_BITS:0]              i_slave_pos_0,
    input  logic [POS_BITS:0]              i_slave_pos_1,
    input  logic [POS_BITS:0]              i_slave_pos_2,
    input  logic [POS_BITS:0]              i_slave_pos_3,
    input  logic [POS_BITS:0]              i_slave_pos_4,
    input  logic [POS_BITS:0]              i_slave_pos_5,
    input  logic [POS_BITS:0]              i_slave_pos_6,
    input  logic [POS_BITS:0]              i_slave_pos_7,
    input  logic                           i_last_residue,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [abx_pkg::ABX_ROW_W-1:0]  o_row,
    output logic [POS_BITS-1:0]            o_range_from,
    output logic [POS_BITS-1:0]            o_range_to,
    output logic                           o_last_row
);

    localparam int ENTRY_W = abx_pkg::abx_entry_width(MAX_SLAVES, POS_BITS);

    logic [abx_pkg::ABX_NUM_PORTS-1:0][POS_BITS:0] w_pos;
    logic                  w_push;
    logic                  w_pop;
    logic [ENTRY_W-1:0]    w_entry_in;
    logic [ENTRY_W-1:0]    w_entry_out;
    abx_pkg::t_q_status    w_q_status;

    assign w_pos = {i_slave_pos_7, i_slave_pos_6, i_slave_pos_5, i_slave_pos_4,
                    i_slave_pos_3, i_slave_pos_2, i_slave_pos_1, i_slave_pos_0};

    abx_front #(
        .MAX_SLAVES (MAX_SLAVES),
        .POS_BITS   (POS_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_slave_pos    (w_pos[MAX_SLAVES-1:0]),
        .i_last_residue (i_last_residue),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_entry        (w_entry_in)
    );

    abx_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (abx_pkg::ABX_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_entry_in),
        .i_pop    (w_pop),
        .o_data   (w_entry_out),
        .o_status (w_q_status)
    );

    abx_back #(
        .MAX_SLAVES (MAX_SLAVES),
        .POS_BITS   (POS_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (w_entry_out),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row        (o_row),
        .o_range_from (o_range_from),
        .o_range_to   (o_range_to),
        .o_last_row   (o_last_row)
    );

endmodule

// File: bench/aligned_block_extractor_tb.sv
// Self-checking bench for aligned_block_extractor: residue beats in, range rows out,
// checked against an in-bench block tracker. Depends on abx_pkg and the block's RTL.
module aligned_block_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ABX_MAX_SLAVES = abx_pkg::ABX_MAX_SLAVES;
    localparam int ABX_POS_BITS   = abx_pkg::ABX_POS_BITS;
    localparam int ABX_CNT_W      = abx_pkg::ABX_CNT_W;
    localparam int ABX_ROW_W      = abx_pkg::ABX_ROW_W;
    localparam logic [ABX_CNT_W-1:0] ABX_CFG_RESET = abx_pkg::ABX_CFG_RESET;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 58;
    localparam logic [ABX_POS_BITS:0] NOT_ALIGNED = '1;

    typedef logic [ABX_POS_BITS-1:0] t_pos;
    typedef logic [ABX_MAX_SLAVES-1:0][ABX_POS_BITS:0] t_pos_vec;

    typedef struct packed {
        logic [ABX_ROW_W-1:0] row;
        t_pos                 from_pos;
        t_pos                 to_pos;
        logic                 last_row;
    } t_row_beat;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [ABX_CNT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 o_in_stall;
    t_pos_vec             pos_bus = '0;
    logic                 last_residue = 1'b0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    logic [ABX_ROW_W-1:0] o_row;
    t_pos                 o_range_from;
    t_pos                 o_range_to;
    logic                 o_last_row;

    // Tracker state for the block.
    logic [ABX_CNT_W-1:0] slave_count_model = ABX_CFG_RESET;
    logic                 blk_open = 1'b0;
    t_pos                 blk_master_start = '0;
    t_pos                 master_idx = '0;
    t_pos                 blk_slave_start [ABX_MAX_SLAVES];

    t_row_beat rows_due [$];
    t_row_beat want_row;
    int        mismatches = 0;
    int        beats_checked = 0;
    int        residues_sent = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    bit        sender_gaps = 1'b1;
    int        hold_left = 0;
    int        mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    logic      beat_fire = 1'b0;
    t_row_beat beat_seen;

    always #5 i_clk = ~i_clk;

    aligned_block_extractor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_slave_pos_0 (pos_bus[0]),
        .i_slave_pos_1 (pos_bus[1]),
        .i_slave_pos_2 (pos_bus[2]),
        .i_slave_pos_3 (pos_bus[3]),
        .i_slave_pos_4 (pos_bus[4]),
        .i_slave_pos_5 (pos_bus[5]),
        .i_slave_pos_6 (pos_bus[6]),
        .i_slave_pos_7 (pos_bus[7]),
        .i_last_residue(last_residue),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_row         (o_row),
        .o_range_from  (o_range_from),
        .o_range_to    (o_range_to),
        .o_last_row    (o_last_row)
    );

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatches = mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver back-pressure: a long hold-off when asked, otherwise a changing pattern.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(4, 40);
            end
            mode_left = mode_left - 1;
            case (stall_mode)
                STALL_NONE:   out_stall = 1'b0;
                STALL_LIGHT:  out_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall = ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: out_stall = ~out_stall;
                default:      out_stall = 1'b0;
            endcase
        end
    end

    // Output beats are captured at the rising edge and checked on the falling edge,
    // after any expectation pushed at the same edge is in place.
    always @(posedge i_clk) begin
        beat_fire <= i_rst_n && o_out_valid && !out_stall;
        beat_seen <= '{o_row, o_range_from, o_range_to, o_last_row};
    end

    always @(negedge i_clk) begin
        if (beat_fire) begin
            beats_checked = beats_checked + 1;
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("beat %0d: row %0d from %0d to %0d with nothing pending",
                                          beats_checked, beat_seen.row, beat_seen.from_pos,
                                          beat_seen.to_pos));
            end else begin
                want_row = rows_due.pop_front();
                if (beat_seen.row !== want_row.row)
                    report_mismatch($sformatf("beat %0d: row expected %0d got %0d",
                                              beats_checked, want_row.row, beat_seen.row));
                if (beat_seen.from_pos !== want_row.from_pos)
                    report_mismatch($sformatf("beat %0d: range_from expected %0d got %0d",
                                              beats_checked, want_row.from_pos,
                                              beat_seen.from_pos));
                if (beat_seen.to_pos !== want_row.to_pos)
                    report_mismatch($sformatf("beat %0d: range_to expected %0d got %0d",
                                              beats_checked, want_row.to_pos, beat_seen.to_pos));
                if (beat_seen.last_row !== want_row.last_row)
                    report_mismatch($sformatf("beat %0d: last_row expected %0d got %0d",
                                              beats_checked, want_row.last_row,
                                              beat_seen.last_row));
            end
        end
    end

    function automatic int active_slaves();
        return (slave_count_model > ABX_MAX_SLAVES) ? ABX_MAX_SLAVES : int'(slave_count_model);
    endfunction

    task automatic add_row_due(input int row, input t_pos from_pos, input t_pos to_pos,
                               input logic last_row);
        t_row_beat r;
        r.row = row[ABX_ROW_W-1:0];
        r.from_pos = from_pos;
        r.to_pos = to_pos;
        r.last_row = last_row;
        rows_due = {rows_due, r};
    endtask

    task automatic close_open_block(input t_pos end_at, input int ns);
        t_pos span;
        int k;
        span = end_at - blk_master_start;
        add_row_due(0, blk_master_start, end_at, ns == 0);
        for (k = 0; k < ns; k++)
            add_row_due(k + 1, blk_slave_start[k], blk_slave_start[k] + span, k + 1 == ns);
        blk_open = 1'b0;
    endtask

    // Advances the tracker by one accepted residue and queues the rows it releases.
    task automatic track_residue(input t_pos_vec pos, input logic last);
        int ns;
        int k;
        logic aligned;
        logic grows;
        t_pos at [ABX_MAX_SLAVES];
        t_pos idx;
        t_pos moff;
        t_pos diff;
        ns = active_slaves();
        aligned = 1'b1;
        idx = master_idx;
        for (k = 0; k < ns; k++) begin
            if (pos[k][ABX_POS_BITS]) begin
                aligned = 1'b0;
                at[k] = '0;
            end else begin
                at[k] = pos[k][ABX_POS_BITS-1:0];
            end
        end
        if (blk_open) begin
            grows = aligned;
            moff = idx - blk_master_start;
            for (k = 0; k < ns; k++) begin
                diff = at[k] - blk_slave_start[k];
                if (diff != moff)
                    grows = 1'b0;
            end
            if (!grows)
                close_open_block(idx - 1'b1, ns);
        end
        if (!blk_open && aligned) begin
            blk_open = 1'b1;
            blk_master_start = idx;
            for (k = 0; k < ns; k++)
                blk_slave_start[k] = at[k];
        end
        if (last) begin
            if (blk_open)
                close_open_block(idx, ns);
            master_idx = '0;
        end else begin
            master_idx = idx + 1'b1;
        end
    endtask

    task automatic send_residue(input t_pos_vec pos, input logic last);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        pos_bus = pos;
        last_residue = last;
        in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        track_residue(pos, last);
        residues_sent = residues_sent + 1;
        if (burst_left > 0)
            burst_left = burst_left - 1;
    endtask

    // Lets every expected row out, then gives the block time to go idle.
    task automatic settle_block();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slave_count(input logic [ABX_CNT_W-1:0] value);
        settle_block();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        slave_count_model = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [ABX_POS_BITS:0] random_position();
        if ($urandom_range(0, 7) == 0)
            return NOT_ALIGNED;
        return {1'b0, t_pos'($urandom_range(0, 65535))};
    endfunction

    task automatic test_directed_blocks();
        t_pos_vec pos;
        t_pos track [ABX_MAX_SLAVES];
        int i;
        int k;
        // One slave; the upper slaves carry values that must be ignored.
        write_slave_count(4'd1);
        pos = {ABX_MAX_SLAVES{NOT_ALIGNED}};
        pos[0] = 17'd0;      send_residue(pos, 1'b0);
        pos[0] = 17'd1;      send_residue(pos, 1'b0);
        pos[0] = NOT_ALIGNED; send_residue(pos, 1'b0);
        // A negative position other than minus one is unaligned as well.
        pos[0] = 17'h10000;  send_residue(pos, 1'b0);
        pos[0] = 17'd65535;  send_residue(pos, 1'b0);
        pos[0] = 17'd0;      send_residue(pos, 1'b0);
        pos[0] = 17'd1;      send_residue(pos, 1'b0);
        // Aligned but off the diagonal, and last: closes one block, opens and flushes another.
        pos[0] = 17'd50;     send_residue(pos, 1'b1);

        // No slaves at all: every residue is aligned and rows are master only.
        write_slave_count(4'd0);
        for (i = 0; i < 3; i++) begin
            for (k = 0; k < ABX_MAX_SLAVES; k++)
                pos[k] = random_position();
            send_residue(pos, i == 2);
        end

        // A count above eight saturates; slave 7 wraps through the top of its range.
        write_slave_count(4'd15);
        for (k = 0; k < ABX_MAX_SLAVES; k++)
            track[k] = t_pos'(k * 1000);
        track[7] = 16'd65534;
        for (i = 0; i < 5; i++) begin
            if (i == 3)
                track[2] = track[2] + 16'd300;
            for (k = 0; k < ABX_MAX_SLAVES; k++)
                pos[k] = {1'b0, track[k]};
            send_residue(pos, i == 4);
            for (k = 0; k < ABX_MAX_SLAVES; k++)
                track[k] = track[k] + 1'b1;
        end

        write_slave_count(4'd8);
        pos = {ABX_MAX_SLAVES{17'h0FFFF}};
        send_residue(pos, 1'b0);
        pos = '0;
        send_residue(pos, 1'b0);
        pos = {ABX_MAX_SLAVES{17'd1}};
        pos[3] = NOT_ALIGNED;
        send_residue(pos, 1'b0);
        pos = {ABX_MAX_SLAVES{17'h0FFFF}};
        send_residue(pos, 1'b0);
        pos[0] = 17'h1FFFE;
        send_residue(pos, 1'b1);
    endtask

    // One master sequence: mostly slaves marching with the master, with
    // shifts, holes and noise that break blocks, ended by a last residue.
    task automatic run_master_sequence(input int len);
        t_pos_vec pos;
        t_pos track [ABX_MAX_SLAVES];
        int ns;
        int i;
        int k;
        int pick;
        int victim;
        ns = active_slaves();
        for (k = 0; k < ABX_MAX_SLAVES; k++)
            track[k] = ($urandom_range(0, 4) == 0) ? t_pos'($urandom_range(65500, 65535))
                                                   : t_pos'($urandom_range(0, 65535));
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            victim = (ns == 0) ? 0 : $urandom_range(0, ns - 1);
            if (pick < 8)
                track[victim] = track[victim] + t_pos'($urandom_range(1, 500));
            for (k = 0; k < ABX_MAX_SLAVES; k++)
                pos[k] = (k < ns) ? {1'b0, track[k]} : random_position();
            if (pick >= 8 && pick < 16)
                pos[victim] = NOT_ALIGNED;
            else if (pick >= 16 && pick < 20)
                pos[victim] = random_position();
            else if (pick >= 20 && pick < 23)
                for (k = 0; k < ABX_MAX_SLAVES; k++)
                    pos[k] = random_position();
            send_residue(pos, i == len - 1);
            for (k = 0; k < ABX_MAX_SLAVES; k++)
                track[k] = track[k] + 1'b1;
        end
    endtask

    task automatic test_random_sequences();
        logic [ABX_CNT_W-1:0] counts [6];
        int p;
        int first;
        counts[0] = 4'd1;
        counts[1] = 4'd8;
        counts[2] = 4'd4;
        counts[3] = 4'($urandom_range(2, 7));
        counts[4] = 4'd9;
        counts[5] = 4'd3;
        for (p = 0; p < 6; p++) begin
            write_slave_count(counts[p]);
            first = residues_sent;
            while (residues_sent - first < PHASE_ITEMS)
                run_master_sequence(($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                                : $urandom_range(1, 16));
        end
    endtask

    // Every residue steps the slaves by two, so each one closes a full block of
    // nine rows while the receiver holds off and the queue backs up.
    task automatic test_full_queue_pressure();
        t_pos_vec pos;
        int i;
        int k;
        write_slave_count(4'd8);
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 30; i++) begin
            for (k = 0; k < ABX_MAX_SLAVES; k++)
                pos[k] = {1'b0, t_pos'(2 * i + k)};
            send_residue(pos, i == 29);
        end
    endtask

    // Sends a long aligned run with no gaps between beats, then breaks it.
    task automatic test_back_to_back_run();
        t_pos_vec pos;
        int i;
        write_slave_count(4'd1);
        sender_gaps = 1'b0;
        pos = '0;
        pos[0] = NOT_ALIGNED;
        for (i = 0; i < 18; i++) begin
            pos[0] = {1'b0, t_pos'(1000 + i)};
            send_residue(pos, 1'b0);
        end
        pos[0] = 17'd5000;
        send_residue(pos, 1'b0);
        pos[0] = 17'd5001;
        send_residue(pos, 1'b1);
        sender_gaps = 1'b1;
    endtask

    initial begin
        for (int k = 0; k < ABX_MAX_SLAVES; k++)
            blk_slave_start[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_blocks();
        test_random_sequences();
        test_full_queue_pressure();
        test_back_to_back_run();

        settle_block();
        if (rows_due.size() != 0)
            report_mismatch($sformatf("%0d rows never emitted", rows_due.size()));
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
